>>> design/stq_pkg.sv
package stq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_BITS       = $clog2(MAX_RESULTS);

    localparam int KIND_BITS = 2;
    localparam int ID_BITS   = 4;
    localparam int TV_BITS   = 32;
    localparam int OUT_BITS  = 32;

    // request kinds
    localparam logic [KIND_BITS-1:0] KIND_SET    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_EXPIRE = 2'd2;

    // cell operations, broadcast to the whole chain
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_REMOVE = 2'd1;
    localparam logic [1:0] CELL_INSERT = 2'd2;
    localparam logic [1:0] CELL_POP    = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_BITS-1:0] id;
    } cell_cmd_t;

endpackage

>>> design/stq_req_if.sv
interface stq_req_if
    import stq_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   timer_id;
    logic [TV_BITS-1:0]   time_value;

    modport source (output valid, kind, timer_id, time_value, input ready);
    modport sink   (input valid, kind, timer_id, time_value, output ready);
endinterface

>>> design/stq_rsp_if.sv
interface stq_rsp_if
    import stq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] head_before;
    logic [OUT_BITS-1:0] head_after;
    logic                expired_valid;
    logic [ID_BITS-1:0]  expired_id;
    logic                last;

    modport source (output valid, head_before, head_after, expired_valid, expired_id, last,
                    input ready);
    modport sink   (input valid, head_before, head_after, expired_valid, expired_id, last,
                    output ready);
endinterface

>>> design/stq_cell.sv
module stq_cell
    import stq_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic [TIME_BITS-1:0] new_time,
    input  logic                 shift_in,
    input  logic                 left_valid,
    input  logic [ID_BITS-1:0]   left_id,
    input  logic [TIME_BITS-1:0] left_time,
    input  logic                 left_gt,
    input  logic                 right_valid,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic [TIME_BITS-1:0] right_time,
    output logic                 valid,
    output logic [ID_BITS-1:0]   id,
    output logic [TIME_BITS-1:0] tm,
    output logic                 match,
    output logic                 gt
);

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] tm_reg, tm_next;

    // empty cells count as later than any time
    assign gt    = !valid_reg || (tm_reg > new_time);
    assign match = valid_reg && (id_reg == cmd.id);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        tm_next    = tm_reg;
        case (cmd.op)
            CELL_REMOVE:
            begin
                if (shift_in)
                begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    tm_next    = right_time;
                end
            end
            CELL_POP:
            begin
                valid_next = right_valid;
                id_next    = right_id;
                tm_next    = right_time;
            end
            CELL_INSERT:
            begin
                valid_next = left_valid;
                if (gt)
                begin
                    if (left_gt)
                    begin
                        id_next = left_id;
                        tm_next = left_time;
                    end
                    else
                    begin
                        id_next = cmd.id;
                        tm_next = new_time;
                    end
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        tm_reg <= tm_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign tm    = tm_reg;

endmodule

>>> design/sorted_timer_queue.sv
// Sorted timer queue. Active timers sit in a chain of NUM_TIMERS cells, earliest expiry
// in cell 0; equal times keep insertion order. For set and clear requests the accept
// cycle removes the timer from the chain (all cells shift in parallel); then the insert
// state inserts it (set), or the finish state (clear), and loads the single response.
// An expire request pops one head per cycle while the response register is free, and
// each pop is one response; at most 16 timers pop per request, the rest stay queued.
// A new request is taken only once the previous one has finished in the chain; a
// response register lets the chain finish while the last response waits. A head of 0
// means empty (or a timer set to 0). Timer ids at or beyond NUM_TIMERS and kind 3 are
// ignored and answered with one response. The queue is empty after reset.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    stq_req_if.sink   req,
    stq_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_EXPIRE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] tv_reg, tv_next;
    logic [OUT_BITS-1:0]  before_reg, before_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [OUT_BITS-1:0] head_before_reg, head_before_next;
    logic [OUT_BITS-1:0] head_after_reg, head_after_next;
    logic                exp_valid_reg, exp_valid_next;
    logic [ID_BITS-1:0]  exp_id_reg, exp_id_next;
    logic                last_reg, last_next;

    // chain taps
    logic                 valid_w [NUM_TIMERS];
    logic [ID_BITS-1:0]   id_w    [NUM_TIMERS];
    logic [TIME_BITS-1:0] tm_w    [NUM_TIMERS];
    logic                 gt_w    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] match_w;
    logic [NUM_TIMERS-1:0] shift_w;

    cell_cmd_t            cmd;
    logic                 out_free;
    logic [OUT_BITS-1:0]  head_cur;
    logic                 id_ok;
    logic                 due0, due1;
    logic                 pop_last;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            logic                 l_valid, l_gt, r_valid;
            logic [ID_BITS-1:0]   l_id, r_id;
            logic [TIME_BITS-1:0] l_tm, r_tm;

            // remove: every cell at or after the matching one takes its right neighbor
            assign shift_w[gi] = |match_w[gi:0];

            if (gi == 0)
            begin : g_head
                assign l_valid = 1'b1;
                assign l_gt    = 1'b0;
                assign l_id    = '0;
                assign l_tm    = '0;
            end
            else
            begin : g_body
                assign l_valid = valid_w[gi-1];
                assign l_gt    = gt_w[gi-1];
                assign l_id    = id_w[gi-1];
                assign l_tm    = tm_w[gi-1];
            end

            if (gi == NUM_TIMERS - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_id    = '0;
                assign r_tm    = '0;
            end
            else
            begin : g_mid
                assign r_valid = valid_w[gi+1];
                assign r_id    = id_w[gi+1];
                assign r_tm    = tm_w[gi+1];
            end

            stq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .new_time    (tv_reg),
                .shift_in    (shift_w[gi]),
                .left_valid  (l_valid),
                .left_id     (l_id),
                .left_time   (l_tm),
                .left_gt     (l_gt),
                .right_valid (r_valid),
                .right_id    (r_id),
                .right_time  (r_tm),
                .valid       (valid_w[gi]),
                .id          (id_w[gi]),
                .tm          (tm_w[gi]),
                .match       (match_w[gi]),
                .gt          (gt_w[gi])
            );
        end
    endgenerate

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign head_cur  = valid_w[0] ? OUT_BITS'(tm_w[0]) : '0;
    assign id_ok     = int'(req.timer_id) < NUM_TIMERS;
    assign due0      = valid_w[0] && (tm_w[0] <= tv_reg);
    assign due1      = valid_w[1] && (tm_w[1] <= tv_reg);
    assign pop_last  = !due1 || (count_reg == CNT_BITS'(MAX_RESULTS - 1));
    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        id_next          = id_reg;
        tv_next          = tv_reg;
        before_next      = before_reg;
        count_next       = count_reg;
        cmd.op           = CELL_HOLD;
        cmd.id           = id_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        head_before_next = head_before_reg;
        head_after_next  = head_after_reg;
        exp_valid_next   = exp_valid_reg;
        exp_id_next      = exp_id_reg;
        last_next        = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    id_next     = req.timer_id;
                    tv_next     = TIME_BITS'(req.time_value);
                    before_next = head_cur;
                    count_next  = '0;
                    state_next  = ST_FINISH;
                    if ((req.kind == KIND_SET || req.kind == KIND_CLEAR) && id_ok)
                    begin
                        // drop any active copy of this timer right away
                        cmd.op = CELL_REMOVE;
                        cmd.id = req.timer_id;
                        if (req.kind == KIND_SET)
                            state_next = ST_INSERT;
                    end
                    else if (req.kind == KIND_EXPIRE)
                    begin
                        state_next = ST_EXPIRE;
                    end
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    head_before_next = before_reg;
                    exp_valid_next   = 1'b0;
                    exp_id_next      = '0;
                    last_next        = 1'b1;
                    if (valid_w[NUM_TIMERS-1])
                    begin
                        // chain full: timer is dropped
                        head_after_next = head_cur;
                    end
                    else
                    begin
                        cmd.op          = CELL_INSERT;
                        head_after_next = gt_w[0] ? OUT_BITS'(tv_reg) : OUT_BITS'(tm_w[0]);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    head_before_next = before_reg;
                    head_after_next  = head_cur;
                    exp_valid_next   = 1'b0;
                    exp_id_next      = '0;
                    last_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_EXPIRE:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    head_before_next = before_reg;
                    if (due0)
                    begin
                        cmd.op          = CELL_POP;
                        exp_valid_next  = 1'b1;
                        exp_id_next     = id_w[0];
                        last_next       = pop_last;
                        // on the final pop the head after is the current second entry, else 0
                        head_after_next = (pop_last && valid_w[1]) ? OUT_BITS'(tm_w[1]) : '0;
                        count_next      = count_reg + CNT_BITS'(1);
                        if (pop_last)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        // nothing due at all
                        exp_valid_next  = 1'b0;
                        exp_id_next     = '0;
                        last_next       = 1'b1;
                        head_after_next = head_cur;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        tv_reg          <= tv_next;
        before_reg      <= before_next;
        head_before_reg <= head_before_next;
        head_after_reg  <= head_after_next;
        exp_valid_reg   <= exp_valid_next;
        exp_id_reg      <= exp_id_next;
        last_reg        <= last_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.head_before   = head_before_reg;
    assign rsp.head_after    = head_after_reg;
    assign rsp.expired_valid = exp_valid_reg;
    assign rsp.expired_id    = exp_id_reg;
    assign rsp.last          = last_reg;

endmodule

>>> dv/sorted_timer_queue_test.sv
module sorted_timer_queue_test
    import stq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run-length knobs
    // ------------------------------------------------------------------
    localparam int RANDOM_REQS  = 200;
    // Once this few requests are left to send, both sides stop idling.
    localparam int CALM_TAIL    = 25;
    // Longest expire pops 16 timers; allow well over its run at the end.
    localparam int DRAIN_CYCLES = 40;
    // Worst case per request: 16 responses, each behind a longest stall, plus a
    // longest send gap and the chain work. The limit is that worst case for
    // each of ~230 requests, taken several times over.
    localparam int CYCLE_LIMIT  = 400000;

    // Kind 3 is not a defined operation; the block answers it with the head.
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam logic [TV_BITS-1:0]   TIME_MAX    = '1;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ID_BITS-1:0]   id;
        logic [TV_BITS-1:0]   tv;
    } timer_req_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] head_before;
        logic [OUT_BITS-1:0] head_after;
        logic                expired_valid;
        logic [ID_BITS-1:0]  expired_id;
        logic                last;
    } timer_report_t;

    // ------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    stq_req_if req_ch ();
    stq_rsp_if rsp_ch ();

    sorted_timer_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    timer_req_t    outgoing_reqs[$];   // requests not yet presented
    timer_report_t queue_reports[$];   // responses still owed by the block

    // Our own copy of the timer chain, earliest expiry first.
    logic [ID_BITS-1:0] chain_ids[$];
    logic [TV_BITS-1:0] chain_times[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  send_gap    = 0;   // idle cycles left on the request side
    int  hold_cnt    = 0;   // stall cycles left on the response side
    bit  req_taken   = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0d] mismatch: %s", cycle_count, msg);
        error_count++;
    endtask

    // Head time as the block reports it: 0 when nothing is queued.
    function automatic logic [TV_BITS-1:0] chain_head();
        return (chain_times.size() > 0) ? chain_times[0] : '0;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: apply one request to the chain copy and queue the
    // responses it must produce.
    // ------------------------------------------------------------------
    task automatic predict_timer_op(input timer_req_t r);
        logic [TV_BITS-1:0] head_prev;
        timer_report_t      rep;
        int                 pos;
        int                 popped;

        head_prev = chain_head();
        popped    = 0;
        rep       = '0;

        if (r.kind == KIND_SET || r.kind == KIND_CLEAR) begin
            // Every 4-bit id is a real slot with 16 timers, so nothing is ignored here.
            if (int'(r.id) < NUM_TIMERS_DEF) begin
                // set re-arms: drop any existing entry first
                for (int i = 0; i < chain_ids.size(); i++) begin
                    if (chain_ids[i] == r.id) begin
                        chain_ids.delete(i);
                        chain_times.delete(i);
                        break;
                    end
                end
                if (r.kind == KIND_SET && chain_ids.size() < NUM_TIMERS_DEF) begin
                    // new timer goes behind every equal time
                    pos = 0;
                    while (pos < chain_times.size() && chain_times[pos] <= r.tv)
                        pos++;
                    chain_ids.insert(pos, r.id);
                    chain_times.insert(pos, r.tv);
                end
            end
        end else if (r.kind == KIND_EXPIRE) begin
            // One response per due timer; the previous one is pushed once
            // we know it is not the final one.
            while (popped < MAX_RESULTS && chain_times.size() > 0 && chain_times[0] <= r.tv)
            begin
                if (popped > 0)
                    queue_reports.push_back(rep);
                rep.head_before   = head_prev;
                rep.head_after    = '0;
                rep.expired_valid = 1'b1;
                rep.expired_id    = chain_ids.pop_front();
                rep.last          = 1'b0;
                void'(chain_times.pop_front());
                popped++;
            end
            if (popped > 0) begin
                rep.head_after = chain_head();
                rep.last       = 1'b1;
                queue_reports.push_back(rep);
            end
        end

        // set, clear, kind 3 and an expire with nothing due: one plain response
        if (popped == 0) begin
            rep.head_before   = head_prev;
            rep.head_after    = chain_head();
            rep.expired_valid = 1'b0;
            rep.expired_id    = '0;
            rep.last          = 1'b1;
            queue_reports.push_back(rep);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Responses are
    // checked before the request at the same edge is predicted; a
    // response can never belong to a request taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        timer_report_t want;
        cycle_count++;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (queue_reports.size() == 0) begin
                    report_mismatch($sformatf("response with none expected (id %0d)",
                                              rsp_ch.expired_id));
                end else begin
                    want = queue_reports.pop_front();
                    if (rsp_ch.head_before !== want.head_before)
                        report_mismatch($sformatf("head_before %h, want %h",
                                                  rsp_ch.head_before, want.head_before));
                    if (rsp_ch.head_after !== want.head_after)
                        report_mismatch($sformatf("head_after %h, want %h",
                                                  rsp_ch.head_after, want.head_after));
                    if (rsp_ch.expired_valid !== want.expired_valid)
                        report_mismatch($sformatf("expired_valid %b, want %b",
                                                  rsp_ch.expired_valid, want.expired_valid));
                    if (rsp_ch.expired_id !== want.expired_id)
                        report_mismatch($sformatf("expired_id %0d, want %0d",
                                                  rsp_ch.expired_id, want.expired_id));
                    if (rsp_ch.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  rsp_ch.last, want.last));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                predict_timer_op('{kind: req_ch.kind, id: req_ch.timer_id,
                                   tv: req_ch.time_value});
                req_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: changes inputs at the falling edge. A request stays
    // up until taken; after that we either idle a burst or present the next.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        timer_req_t nxt;
        if (rst_n && (!req_ch.valid || req_taken)) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end else if (outgoing_reqs.size() > 0) begin
                nxt = outgoing_reqs.pop_front();
                req_ch.kind       <= nxt.kind;
                req_ch.timer_id   <= nxt.id;
                req_ch.time_value <= nxt.tv;
                req_ch.valid      <= 1'b1;
                // occasional idle burst after this request; none near the end
                if (outgoing_reqs.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 18);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response back-pressure: random stall bursts, none near the end.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_cnt == 0 && outgoing_reqs.size() >= CALM_TAIL
                && $urandom_range(0, 7) == 0)
                hold_cnt = $urandom_range(1, 18);
            rsp_ch.ready <= (hold_cnt == 0);
            if (hold_cnt > 0)
                hold_cnt--;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_req(input logic [KIND_BITS-1:0] kind,
                                    input logic [ID_BITS-1:0] id,
                                    input logic [TV_BITS-1:0] tv);
        outgoing_reqs.push_back('{kind: kind, id: id, tv: tv});
    endfunction

    initial begin
        logic [TV_BITS-1:0] now_t;
        logic [TV_BITS-1:0] tie_t;
        int                 roll;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_SET;
        req_ch.timer_id    = '0;
        req_ch.time_value  = '0;
        rsp_ch.ready       = 1'b0;

        // --- directed part ---
        add_req(KIND_EXPIRE, 4'd0, '0);               // expire on an empty queue
        add_req(KIND_CLEAR, 4'd5, 32'd77);            // clear of an inactive timer
        add_req(KIND_SET, 4'd0, '0);                  // time 0: head reads 0 though queued
        add_req(KIND_SET, 4'd15, TIME_MAX);           // latest possible time
        add_req(KIND_SET, 4'd3, 32'd100);
        add_req(KIND_SET, 4'd7, 32'd100);             // tie: goes behind id 3
        add_req(KIND_SET, 4'd3, 32'd100);             // re-set an active timer: now behind 7
        add_req(KIND_UNUSED, 4'd10, 32'h5A5A_5A5A);   // undefined kind, queue untouched
        add_req(KIND_CLEAR, 4'd7, 32'hA5A5_A5A5);     // clear of an active timer
        add_req(KIND_EXPIRE, 4'd9, 32'd99);           // pops only the time-0 timer
        add_req(KIND_EXPIRE, 4'd0, TIME_MAX);         // drains everything left
        // full queue with ties, then one expire that pops all sixteen
        for (int i = 15; i >= 0; i--)
            add_req(KIND_SET, ID_BITS'(i), 32'd500 + 32'(i / 3));
        add_req(KIND_EXPIRE, 4'd0, TIME_MAX);

        // --- random part: a moving "now" so most expires find work ---
        now_t = 32'd1000;
        tie_t = now_t;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                if ($urandom_range(0, 9) == 0)
                    add_req(KIND_SET, ID_BITS'($urandom), tie_t);   // deliberate tie
                else if ($urandom_range(0, 19) == 0)
                    add_req(KIND_SET, ID_BITS'($urandom), $urandom); // far-off time
                else begin
                    tie_t = now_t + $urandom_range(0, 150);
                    add_req(KIND_SET, ID_BITS'($urandom), tie_t);
                end
            end else if (roll < 60) begin
                add_req(KIND_CLEAR, ID_BITS'($urandom), $urandom);
            end else if (roll < 93) begin
                if ($urandom_range(0, 19) == 0)
                    add_req(KIND_EXPIRE, ID_BITS'($urandom), TIME_MAX);
                else begin
                    now_t = now_t + $urandom_range(0, 120);
                    add_req(KIND_EXPIRE, ID_BITS'($urandom), now_t);
                end
            end else begin
                add_req(KIND_UNUSED, ID_BITS'($urandom), $urandom);
            end
        end

        // --- reset: held, then released on a falling edge ---
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- wind down ---
        while (outgoing_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (queue_reports.size() != 0)
            @(posedge clk);
        // anything arriving now is a spurious response
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout guard.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, queue_reports.size());
        $display("status: fail");
        $finish;
    end

endmodule
